[hw/rtl/byte_ring_fifo_with_delimiter_search_macros.svh]
// Assertion macros for the byte ring FIFO checker.
`ifndef BYTE_RING_FIFO_WITH_DELIMITER_SEARCH_MACROS_SVH
`define BYTE_RING_FIFO_WITH_DELIMITER_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/brfd_pkg.sv]
// Shared types and constants of the byte ring FIFO with delimiter search.
`default_nettype none

package brfd_pkg;

  localparam int Depth     = 256;
  localparam int MaxLenMax = 64;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_POP_DLM = 3'd2,
    OP_MEASURE = 3'd3,
    OP_FIND    = 3'd4,
    OP_CLEAR   = 3'd5
  } brfd_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_LONG  = 2'd3
  } brfd_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_REQ,
    S_SCAN_CMP,
    S_FOUND,
    S_MISS,
    S_READ_REQ,
    S_READ_DATA
  } brfd_state_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_in;
    logic       burst_end;
    logic [7:0] key_byte;
    logic [6:0] max_len;
  } brfd_item_t;

  typedef struct packed {
    logic [7:0]   data_out;
    logic         last;
    brfd_status_e status;
    logic [7:0]   count;
    logic [7:0]   position;
    logic [7:0]   fill_level;
  } brfd_result_t;

endpackage

`default_nettype wire

[hw/rtl/brfd_stream_if.sv]
// Valid/ready stream interfaces for the item and result channels.
`default_nettype none

interface brfd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_in;
  logic       burst_end;
  logic [7:0] key_byte;
  logic [6:0] max_len;

  modport source (output valid, operation, data_in, burst_end, key_byte, max_len,
                  input ready);
  modport sink   (input valid, operation, data_in, burst_end, key_byte, max_len,
                  output ready);
endinterface

interface brfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last;
  logic [1:0] status;
  logic [7:0] count;
  logic [7:0] position;
  logic [7:0] fill_level;

  modport source (output valid, data_out, last, status, count, position, fill_level,
                  input ready);
  modport sink   (input valid, data_out, last, status, count, position, fill_level,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/brfd_mem.sv]
// Byte store of the ring: one write port, one read port with registered data.
`default_nettype none

module brfd_mem #(
  parameter int DEPTH = brfd_pkg::Depth,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [7:0]    rdata_o
);

  logic [7:0] store_q [DEPTH];
  logic [7:0] rdata_q;

  // Write on push, load read data only on a read request so it holds.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/brfd_seq.sv]
// Sequencer: pointers, burst count and the shared slot compare/step unit.
`default_nettype none

module brfd_seq #(
  parameter int DEPTH = brfd_pkg::Depth,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire brfd_pkg::brfd_item_t  item_i,
  input  wire logic                  out_free_i,
  output      logic                  res_valid_o,
  output      brfd_pkg::brfd_result_t res_o,
  output      logic                  mem_we_o,
  output      logic [AW-1:0]         mem_waddr_o,
  output      logic [7:0]            mem_wdata_o,
  output      logic                  mem_re_o,
  output      logic [AW-1:0]         mem_raddr_o,
  input  wire logic [7:0]            mem_rdata_i
);

  localparam int CW = (AW > 7) ? AW : 7;
  localparam logic [AW:0] DepthW = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  brfd_pkg::brfd_state_e state_q, state_d;
  brfd_pkg::brfd_item_t  item_q, item_d;
  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [7:0]    burst_q, burst_d;
  logic [AW-1:0] idx_q, idx_d, sp_q, sp_d, slot_q, slot_d, fill_aft_q, fill_aft_d;
  logic [CW-1:0] cnt_q, cnt_d, run_q, run_d;

  logic [AW-1:0] fill;
  logic          full;
  logic [6:0]    len_c;
  logic [CW-1:0] pop_n;
  logic [7:0]    burst_inc;
  logic [7:0]    burst_new;
  logic          pop_last;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  // Fill level and clamped length.
  assign fill = (wp_q >= rp_q) ? (wp_q - rp_q)
                               : AW'(DepthW - {1'b0, rp_q} + {1'b0, wp_q});
  assign full = (fill == LastSlot);
  assign len_c = (item_q.max_len == 7'd0) ? 7'd1 :
                 (item_q.max_len > 7'(brfd_pkg::MaxLenMax)) ? 7'(brfd_pkg::MaxLenMax) :
                 item_q.max_len;
  assign pop_n = (CW'(fill) > CW'(len_c)) ? CW'(len_c) : CW'(fill);
  assign burst_inc = (burst_q == 8'hFF) ? burst_q : burst_q + 8'd1;
  assign burst_new = full ? burst_q : burst_inc;
  assign pop_last = ((CW'(idx_q) + CW'(1)) == cnt_q);

  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = item_q.data_in;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brfd_pkg::S_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
      burst_q <= '0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      burst_q <= burst_d;
    end
  end

  // Item and scan payload.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    idx_q      <= idx_d;
    sp_q       <= sp_d;
    slot_q     <= slot_d;
    fill_aft_q <= fill_aft_d;
    cnt_q      <= cnt_d;
    run_q      <= run_d;
  end

  // Next state and outputs.
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    burst_d    = burst_q;
    idx_d      = idx_q;
    sp_d       = sp_q;
    slot_d     = slot_q;
    fill_aft_d = fill_aft_q;
    cnt_d      = cnt_q;
    run_d      = run_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_q;

    res_o.data_out   = '0;
    res_o.last       = 1'b1;
    res_o.status     = brfd_pkg::ST_OK;
    res_o.count      = '0;
    res_o.position   = '0;
    res_o.fill_level = 8'(fill);

    unique case (state_q)
      brfd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = item_i;
          state_d = brfd_pkg::S_DECODE;
        end
      end

      brfd_pkg::S_DECODE: begin
        unique case (item_q.operation)
          brfd_pkg::OP_PUSH: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              res_o.count = burst_new;
              if (full) begin
                res_o.status = brfd_pkg::ST_FULL;
              end else begin
                mem_we_o         = 1'b1;
                wp_d             = inc_ptr(wp_q);
                res_o.fill_level = 8'(fill + 1'b1);
              end
              burst_d = item_q.burst_end ? 8'd0 : burst_new;
              state_d = brfd_pkg::S_IDLE;
            end
          end
          brfd_pkg::OP_POP: begin
            if (fill == '0) begin
              if (out_free_i) begin
                res_valid_o  = 1'b1;
                res_o.status = brfd_pkg::ST_EMPTY;
                state_d      = brfd_pkg::S_IDLE;
              end
            end else begin
              cnt_d      = pop_n;
              fill_aft_d = fill - AW'(pop_n);
              idx_d      = '0;
              state_d    = brfd_pkg::S_READ_REQ;
            end
          end
          brfd_pkg::OP_POP_DLM, brfd_pkg::OP_MEASURE, brfd_pkg::OP_FIND: begin
            if (fill == '0) begin
              if (out_free_i) begin
                res_valid_o  = 1'b1;
                res_o.status = brfd_pkg::ST_EMPTY;
                state_d      = brfd_pkg::S_IDLE;
              end
            end else begin
              idx_d   = '0;
              sp_d    = rp_q;
              state_d = brfd_pkg::S_SCAN_REQ;
            end
          end
          brfd_pkg::OP_CLEAR: begin
            if (out_free_i) begin
              res_valid_o      = 1'b1;
              res_o.fill_level = '0;
              rp_d             = '0;
              wp_d             = '0;
              state_d          = brfd_pkg::S_IDLE;
            end
          end
          default: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              state_d     = brfd_pkg::S_IDLE;
            end
          end
        endcase
      end

      // Fetch the next slot of the search.
      brfd_pkg::S_SCAN_REQ: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = sp_q;
        state_d     = brfd_pkg::S_SCAN_CMP;
      end

      // Compare the slot against the delimiter, then step or stop.
      brfd_pkg::S_SCAN_CMP: begin
        if (mem_rdata_i == item_q.key_byte) begin
          run_d   = CW'(idx_q) + CW'(1);
          slot_d  = sp_q;
          state_d = brfd_pkg::S_FOUND;
        end else if ((idx_q + 1'b1) == fill) begin
          state_d = brfd_pkg::S_MISS;
        end else begin
          idx_d   = idx_q + 1'b1;
          sp_d    = inc_ptr(sp_q);
          state_d = brfd_pkg::S_SCAN_REQ;
        end
      end

      brfd_pkg::S_FOUND: begin
        unique case (item_q.operation)
          brfd_pkg::OP_MEASURE: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              res_o.count = 8'(run_q);
              state_d     = brfd_pkg::S_IDLE;
            end
          end
          brfd_pkg::OP_FIND: begin
            if (out_free_i) begin
              res_valid_o    = 1'b1;
              res_o.position = 8'(slot_q);
              state_d        = brfd_pkg::S_IDLE;
            end
          end
          default: begin
            // Pop through the delimiter only when the run fits.
            if (run_q > CW'(len_c)) begin
              if (out_free_i) begin
                res_valid_o  = 1'b1;
                res_o.status = brfd_pkg::ST_LONG;
                res_o.count  = 8'(run_q);
                state_d      = brfd_pkg::S_IDLE;
              end
            end else begin
              cnt_d      = run_q;
              fill_aft_d = fill - AW'(run_q);
              idx_d      = '0;
              state_d    = brfd_pkg::S_READ_REQ;
            end
          end
        endcase
      end

      brfd_pkg::S_MISS: begin
        if (out_free_i) begin
          res_valid_o  = 1'b1;
          res_o.status = brfd_pkg::ST_EMPTY;
          state_d      = brfd_pkg::S_IDLE;
        end
      end

      // Fetch the byte at the read pointer.
      brfd_pkg::S_READ_REQ: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = rp_q;
        state_d     = brfd_pkg::S_READ_DATA;
      end

      // Hand out one popped byte and advance the read pointer.
      brfd_pkg::S_READ_DATA: begin
        if (out_free_i) begin
          res_valid_o      = 1'b1;
          res_o.data_out   = mem_rdata_i;
          res_o.last       = pop_last;
          res_o.count      = 8'(cnt_q);
          res_o.fill_level = 8'(fill_aft_q);
          rp_d             = inc_ptr(rp_q);
          if (pop_last) begin
            state_d = brfd_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = brfd_pkg::S_READ_REQ;
          end
        end
      end

      default: begin
        state_d = brfd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/byte_ring_fifo_with_delimiter_search.sv]
// Top level of the byte ring FIFO with delimiter search.
//
//  channel | dir | transfer moves                                   | handshake
//  in_i    | in  | operation, data_in, burst_end, key_byte, max_len | valid/ready
//  out_o   | out | data_out, last, status, count, position, fill    | valid/ready
//
// Push, clear and unused codes answer from the decode state; a pop reads and hands out
// its bytes one at a time. Search, measure and pop through the delimiter examine slots
// in turn (one read of the single byte-store port, one compare), and a pop through the
// delimiter then hands out its bytes one at a time; on an empty ring they answer at once.
// Reset zeroes the pointers and the burst count; the byte store is not cleared.
// A full output register stalls the sequencer; ready is high only between items.
`default_nettype none

module byte_ring_fifo_with_delimiter_search #(
  parameter int DEPTH = brfd_pkg::Depth
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  brfd_in_if.sink     in_i,
  brfd_out_if.source  out_o
);

  localparam int AW = $clog2(DEPTH);

  brfd_pkg::brfd_item_t   item;
  brfd_pkg::brfd_result_t res, res_q;
  logic                   res_valid;
  logic                   ov_q;
  logic                   out_free;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata, mem_rdata;

  // Pack the incoming transfer.
  always_comb begin
    item.operation = in_i.operation;
    item.data_in   = in_i.data_in;
    item.burst_end = in_i.burst_end;
    item.key_byte  = in_i.key_byte;
    item.max_len   = in_i.max_len;
  end

  assign out_free = !ov_q || out_o.ready;

  brfd_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  brfd_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_free) begin
      ov_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.data_out   = res_q.data_out;
  assign out_o.last       = res_q.last;
  assign out_o.status     = res_q.status;
  assign out_o.count      = res_q.count;
  assign out_o.position   = res_q.position;
  assign out_o.fill_level = res_q.fill_level;

endmodule

`default_nettype wire

[hw/rtl/brfd_checker.sv]
// Port-level checks of the byte ring FIFO, bound to the top level.
`default_nettype none
`include "byte_ring_fifo_with_delimiter_search_macros.svh"

module brfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_last_i,
  input wire logic [1:0] out_status_i,
  input wire logic [7:0] out_data_i
);

  // One item at a time: ready drops after each accepted transfer.
  `BRFD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready stayed high after an accepted item")

  // A pop in progress keeps the input closed.
  `BRFD_ASSERT_SAME(a_closed_mid_pop, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "input ready while a pop is still delivering bytes")

  // Only pops give several results, and those are all successful.
  `BRFD_ASSERT_SAME(a_mid_pop_ok, clk_i, rst_ni, out_valid_i && !out_last_i, out_status_i == brfd_pkg::ST_OK, "non-final result with an error status")

  // A stalled result holds.
  `BRFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result dropped or changed")

endmodule

bind byte_ring_fifo_with_delimiter_search brfd_checker u_brfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_last_i   (out_o.last),
  .out_status_i (out_o.status),
  .out_data_i   (out_o.data_out)
);

`default_nettype wire
